### hw/rtl/vehicle_can_signal_decoder_macros.svh
// assertion macros shared by the checker
// no dependencies
`ifndef VEHICLE_CAN_SIGNAL_DECODER_MACROS_SVH
`define VEHICLE_CAN_SIGNAL_DECODER_MACROS_SVH
// implication checked every clock outside reset
`define VCSD_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
// next-cycle implication
`define VCSD_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

### hw/rtl/vcsd_pkg.sv
// shared types, constants and helpers for the can signal decoder
// no dependencies
`default_nettype none
package vcsd_pkg;
  localparam int unsigned NumOps = 4;
  localparam logic [13:0] ThrReset = 14'd400;
  localparam logic [7:0]  KickdownMark = 8'hB4;
  localparam logic [7:0]  KeyPos2Byte = 8'h45;
  localparam logic [7:0]  KeyCrankByte = 8'h55;
  localparam logic [7:0]  GearParkByte = 8'hE3;
  localparam logic [7:0]  GearRevByte = 8'hC2;

  // back-end operation kinds
  typedef enum logic [2:0] {
    OP_DIRECT = 3'd0,
    OP_THROTTLE = 3'd1,
    OP_SPEED = 3'd2,
    OP_STEER = 3'd3,
    OP_BATTERY = 3'd4
  } op_kind_t;

  // one queued result job
  typedef struct packed {
    logic [4:0]  code;
    op_kind_t    kind;
    logic [39:0] value;  // direct value or operand
    logic        kick;
    logic        last;
    logic [2:0]  key_position;
    logic [1:0]  ignition_state;
    logic        engine_running;
    logic        engine_cranking;
  } job_t;

  // window and brake scaling, exact integer forms
  // 255/80 reduces to 51/16
  function automatic logic [7:0] win_scale(input logic [7:0] b);
    logic [7:0] m;
    logic [15:0] p;
    m = (b < 8'h50) ? b : 8'h50;
    p = 16'(m) * 16'd51;
    return 8'(p >> 4);
  endfunction

  function automatic logic [7:0] brake_scale(input logic [7:0] b);
    logic [7:0] m;
    logic [15:0] p;
    m = (b < 8'h80) ? b : 8'h80;
    p = 16'(m) * 16'd255;
    return 8'(p >> 7);
  endfunction
endpackage
`default_nettype wire

### hw/rtl/vcsd_front.sv
// front end: state update, classification of a frame into result jobs
// uses vcsd_pkg
`default_nettype none
module vcsd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [10:0]        can_id,
  input  wire logic [3:0]         frame_length,
  input  wire logic [63:0]        data,
  input  wire logic [13:0]        thr,
  output vcsd_pkg::job_t          job,
  output logic                    job_valid,
  input  wire logic               job_ready
);
  logic [13:0] engine_speed;
  logic [7:0]  key_raw_byte;
  logic        key_seen;
  logic        engine_flag;
  // held frame and job pointer
  logic        busy;
  logic [10:0] id_r;
  logic [3:0]  len_r;
  logic [7:0]  b [8];
  logic [1:0]  idx;
  logic [2:0]  cnt;
  vcsd_pkg::job_t jobs [vcsd_pkg::NumOps];
  logic [13:0] es_n;
  logic [7:0]  kb_n;
  logic        ks_n, ef_n;
  logic [2:0]  kp;
  logic [1:0]  ign;
  logic        run, crank, above, below, kp34;
  logic [15:0] u10, u32, u54, u76;
  logic [2:0]  gear;
  logic [3:0]  l;
  logic        take;
  logic        done;

  // held frame finishes when its last job leaves or it has none
  assign done = busy && ((cnt == 3'd0) || (job_ready && job.last));
  assign in_ready = !busy || done;
  assign take = in_valid && in_ready;
  assign l = (len_r > 4'd8) ? 4'd8 : len_r;
  assign u10 = {b[1], b[0]};
  assign u32 = {b[3], b[2]};
  assign u54 = {b[5], b[4]};
  assign u76 = {b[7], b[6]};

  // state after this frame
  always_comb begin
    es_n = engine_speed;
    kb_n = key_raw_byte;
    ks_n = key_seen;
    ef_n = engine_flag;
    if (l != 4'd0) begin
      if (id_r == 11'h0AA && l > 4'd5) es_n = u54[15:2];
      if (id_r == 11'h130) begin
        kb_n = b[0];
        ks_n = 1'b1;
      end
      if (id_r == 11'h3B4 && l > 4'd2) ef_n = (b[2] == 8'd0);
    end
  end

  // derived status
  always_comb begin
    if (!ks_n) kp = 3'd0;
    else begin
      case (kb_n)
        8'h40: kp = 3'd1;
        8'h41: kp = 3'd2;
        vcsd_pkg::KeyPos2Byte: kp = 3'd3;
        vcsd_pkg::KeyCrankByte: kp = 3'd4;
        default: kp = 3'd0;
      endcase
    end
    above = es_n > thr;
    below = es_n < thr;
    kp34 = (kp == 3'd3) || (kp == 3'd4);
    if (above) ign = 2'd2;
    else if (ks_n) ign = kp34 ? 2'd1 : 2'd0;
    else ign = ef_n ? 2'd1 : 2'd0;
    if (ks_n) begin
      run = kp34 && above;
      crank = (kp == 3'd4) && below;
    end else begin
      run = ef_n && above;
      crank = ef_n && (es_n != 14'd0) && below;
    end
    case (b[0])
      vcsd_pkg::GearParkByte: gear = 3'd1;
      vcsd_pkg::GearRevByte: gear = 3'd2;
      8'hD1: gear = 3'd3;
      8'hC7: gear = 3'd4;
      default: gear = 3'd0;
    endcase
  end

  // build the job list for the held frame
  always_comb begin
    vcsd_pkg::job_t t;
    t = '0;
    t.key_position = kp;
    t.ignition_state = ign;
    t.engine_running = run;
    t.engine_cranking = crank;
    t.kind = vcsd_pkg::OP_DIRECT;
    cnt = 3'd0;
    for (int i = 0; i < vcsd_pkg::NumOps; i++) jobs[2'(i)] = t;
    if (l != 4'd0) begin
      case (id_r)
        11'h0A8: begin
          if (l > 4'd1) begin
            jobs[cnt[1:0]].code = 5'd0;
            jobs[cnt[1:0]].value = (b[1][7:4] == 4'd6) ? 40'd256 : 40'd0;
            cnt = cnt + 3'd1;
          end
          if (l > 4'd2) begin
            jobs[cnt[1:0]].code = 5'd1;
            jobs[cnt[1:0]].value = {{21{b[2][7]}}, b[2], b[1], 3'd0};
            cnt = cnt + 3'd1;
          end
        end
        11'h0AA: begin
          if (l > 4'd5) begin
            jobs[cnt[1:0]].code = 5'd2;
            jobs[cnt[1:0]].value = {18'd0, u54[15:2], 8'd0};
            cnt = cnt + 3'd1;
          end
          if (l > 4'd3) begin
            jobs[cnt[1:0]].code = 5'd3;
            jobs[cnt[1:0]].kind = vcsd_pkg::OP_THROTTLE;
            jobs[cnt[1:0]].value = {24'd0, u32};
            jobs[cnt[1:0]].kick = (l > 4'd6) && (b[6] == vcsd_pkg::KickdownMark);
            cnt = cnt + 3'd1;
          end
        end
        11'h130: begin
          jobs[0].code = 5'd4;
          jobs[0].value = {24'd0, b[0], 8'd0};
          cnt = 3'd1;
        end
        11'h1A1: if (l > 4'd3) begin
          jobs[0].code = 5'd5;
          jobs[0].kind = vcsd_pkg::OP_SPEED;
          jobs[0].value = {24'd0, u32};
          cnt = 3'd1;
        end
        11'h0C8: if (l > 4'd1) begin
          jobs[0].code = 5'd6;
          jobs[0].kind = vcsd_pkg::OP_STEER;
          jobs[0].value = {{24{b[1][7]}}, u10};
          cnt = 3'd1;
        end
        11'h0E2: begin
          jobs[0].code = 5'd7;
          jobs[0].value = (b[0] == 8'h02) ? 40'd256 : 40'd0;
          cnt = 3'd1;
        end
        11'h0E6: if (l > 4'd2) begin
          jobs[0].code = 5'd8;
          jobs[0].value = (b[2] == 8'hFD) ? 40'd256 : 40'd0;
          cnt = 3'd1;
        end
        11'h0F6: begin
          jobs[0].code = 5'd9;
          jobs[0].value = (b[0] == 8'hF3) ? 40'd256 : 40'd0;
          cnt = 3'd1;
        end
        11'h1B4: if (l > 4'd5) begin
          jobs[0].code = 5'd10;
          jobs[0].value = (b[5] == 8'h32) ? 40'd256 : 40'd0;
          cnt = 3'd1;
        end
        11'h1D0: begin
          jobs[0].code = 5'd11;
          jobs[0].value = {40'($signed({1'b0, b[0]}) - 9'sd48)} << 8;
          cnt = 3'd1;
        end
        11'h1D6: if (l > 4'd1) begin
          jobs[0].code = 5'd12;
          jobs[0].value = {16'd0, b[0], b[1], 8'd0};
          cnt = 3'd1;
        end
        11'h1E1: if (l > 4'd2) begin
          jobs[0].code = 5'd13;
          jobs[0].value = (b[2][3:0] == 4'd1) ? 40'd256 : 40'd0;
          cnt = 3'd1;
        end
        11'h286: if (l > 4'd1) begin
          jobs[0].code = 5'd14;
          jobs[0].value = {24'd0, b[1], 8'd0};
          cnt = 3'd1;
        end
        11'h2B2: begin
          jobs[0].code = 5'd15;
          jobs[0].value = {24'd0, vcsd_pkg::brake_scale(b[0]), 8'd0};
          cnt = 3'd1;
        end
        11'h2F1: if (l > 4'd2) begin
          jobs[0].code = 5'd16;
          jobs[0].value = b[2][0] ? 40'd256 : 40'd0;
          cnt = 3'd1;
        end
        11'h2FC: if (l > 4'd1) begin
          for (int i = 0; i < 4; i++) begin
            jobs[2'(i)].code = 5'(17 + i);
            jobs[2'(i)].value = b[1][3'(2*i)] ? 40'd256 : 40'd0;
          end
          cnt = 3'd4;
        end
        11'h304: begin
          jobs[0].code = 5'd21;
          jobs[0].value = {29'd0, gear, 8'd0};
          cnt = 3'd1;
        end
        11'h330: begin
          if (l > 4'd2) begin
            jobs[cnt[1:0]].code = 5'd22;
            jobs[cnt[1:0]].value = {8'd0, b[2], b[1], b[0], 8'd0};
            cnt = cnt + 3'd1;
          end
          if (l > 4'd3) begin
            jobs[cnt[1:0]].code = 5'd23;
            jobs[cnt[1:0]].value = {24'd0, b[3], 8'd0};
            cnt = cnt + 3'd1;
          end
          if (l > 4'd7) begin
            jobs[cnt[1:0]].code = 5'd24;
            jobs[cnt[1:0]].value = {20'd0, u76, 4'd0};
            cnt = cnt + 3'd1;
          end
        end
        11'h3B4: begin
          if (l > 4'd1) begin
            jobs[cnt[1:0]].code = 5'd25;
            jobs[cnt[1:0]].kind = vcsd_pkg::OP_BATTERY;
            jobs[cnt[1:0]].value = {24'd0, u10};
            cnt = cnt + 3'd1;
          end
          if (l > 4'd2) begin
            jobs[cnt[1:0]].code = 5'd26;
            jobs[cnt[1:0]].value = (b[2] == 8'd0) ? 40'd256 : 40'd0;
            cnt = cnt + 3'd1;
          end
        end
        11'h3B6, 11'h3B7, 11'h3B8, 11'h3B9: begin
          jobs[0].code = 5'd27 + 5'(id_r[3:0] - 4'h6);
          jobs[0].value = {24'd0, vcsd_pkg::win_scale(b[0]), 8'd0};
          cnt = 3'd1;
        end
        default: cnt = 3'd0;
      endcase
    end
  end

  always_comb begin
    job = jobs[idx];
    job.last = ({1'b0, idx} + 3'd1) == cnt;
    job_valid = busy && (cnt != 3'd0);
  end

  // capture a frame, walk its jobs, commit state when the held frame finishes
  always_ff @(posedge clk) begin
    if (take) begin
      id_r <= can_id;
      len_r <= frame_length;
      for (int i = 0; i < 8; i++) b[3'(i)] <= data[8*i +: 8];
    end
    if (rst) begin
      busy <= 1'b0;
      idx <= 2'd0;
      engine_speed <= '0;
      key_raw_byte <= '0;
      key_seen <= 1'b0;
      engine_flag <= 1'b0;
    end else begin
      if (done) begin
        engine_speed <= es_n;
        key_raw_byte <= kb_n;
        key_seen <= ks_n;
        engine_flag <= ef_n;
      end
      if (take) begin
        busy <= 1'b1;
        idx <= 2'd0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (busy && job_ready) begin
        idx <= idx + 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/vcsd_queue.sv
// two-entry job queue between front and back
// uses vcsd_pkg
`default_nettype none
module vcsd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire vcsd_pkg::job_t wr_job,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  output vcsd_pkg::job_t      rd_job,
  output logic                rd_valid,
  input  wire logic           rd_ready
);
  vcsd_pkg::job_t mem [2];
  logic wp, rp;
  logic [1:0] count;
  logic wr, rd;
  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_job = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_job;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

### hw/rtl/vcsd_back.sv
// back end: scaling arithmetic in two stages with an output register
// uses vcsd_pkg
`default_nettype none
module vcsd_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire vcsd_pkg::job_t job,
  input  wire logic           job_valid,
  output logic                job_ready,
  output vcsd_pkg::job_t      res,
  output logic                res_valid,
  input  wire logic           res_ready
);
  // stage 1: multiply by reciprocal
  vcsd_pkg::job_t s1;
  logic s1_v;
  logic [47:0] prod;   // magnitude times reciprocal
  logic        neg, neg_r;
  logic [23:0] mag, mag_r;
  logic [23:0] recip;
  logic [23:0] dvs, dvs_r;
  logic        adv1, adv2;
  logic [39:0] fin;
  logic [23:0] q0, qc;
  logic [47:0] rem;
  vcsd_pkg::job_t res_next;

  assign adv2 = !res_valid || res_ready;
  assign adv1 = !s1_v || adv2;
  assign job_ready = adv1;

  // operand and reciprocal select, dividend below 2^24
  always_comb begin
    neg = 1'b0;
    mag = '0;
    recip = '0;
    dvs = 24'd1;
    case (job.kind)
      vcsd_pkg::OP_THROTTLE: begin
        mag = (job.value[15:0] > 16'd255) ? 24'(job.value[15:0] - 16'd255) * 24'd254 : 24'd0;
        dvs = 24'd64809;
        recip = 24'd258;          // floor(2^24/64809)
      end
      vcsd_pkg::OP_SPEED: begin
        mag = {job.value[15:0], 8'd0};
        dvs = 24'd100;
        recip = 24'd167772;
      end
      vcsd_pkg::OP_STEER: begin
        neg = job.value[15];
        mag = {neg ? 16'(-job.value[15:0]) : job.value[15:0], 8'd0};
        dvs = 24'd23;
        recip = 24'd729444;
      end
      vcsd_pkg::OP_BATTERY: begin
        neg = job.value[15:0] < 16'hF000;
        mag = {neg ? 16'(16'hF000 - job.value[15:0]) : 16'(job.value[15:0] - 16'hF000), 8'd0};
        dvs = 24'd68;
        recip = 24'd246723;
      end
      default: mag = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1 <= job;
      prod <= 48'(mag) * 48'(recip);
      mag_r <= mag;
      dvs_r <= dvs;
      neg_r <= neg;
    end
    if (rst) s1_v <= 1'b0;
    else if (adv1) s1_v <= job_valid;
  end

  // stage 2: correct quotient estimate, sign, throttle clamp
  always_comb begin
    q0 = prod[47:24];
    rem = 48'(mag_r) - 48'(q0) * 48'(dvs_r);
    qc = q0;
    if (rem >= 48'(dvs_r)) qc = q0 + 24'd1;
    if (rem >= 48'(2 * dvs_r)) qc = q0 + 24'd2;
    fin = s1.value;
    case (s1.kind)
      vcsd_pkg::OP_THROTTLE: begin
        if (s1.kick) fin = 40'd255 << 8;
        else fin = {24'd0, (qc > 24'd254) ? 8'd254 : qc[7:0], 8'd0};
      end
      vcsd_pkg::OP_SPEED: fin = 40'(qc);
      vcsd_pkg::OP_STEER, vcsd_pkg::OP_BATTERY:
        fin = neg_r ? -40'(qc) : 40'(qc);
      default: fin = s1.value;
    endcase
    res_next = s1;
    res_next.value = fin;
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v) res <= res_next;
    if (rst) res_valid <= 1'b0;
    else if (adv2) res_valid <= s1_v;
  end
endmodule
`default_nettype wire

### hw/rtl/vehicle_can_signal_decoder.sv
// top level of the can signal decoder
// uses vcsd_pkg, vcsd_front, vcsd_queue, vcsd_back
// Takes received CAN frames on s_axis (one transaction per frame) and
// sends one transaction per decoded signal on m_axis: signal code on
// tuser, value and status on tdata, tlast on the final result of a frame.
// cfg_* writes the running rpm threshold (reset 400).
// The front end holds a frame while it hands its results to the queue,
// which can stall it, and takes the next frame in the cycle its last
// job leaves (for a frame with none, as soon as it is held); the front-end
// job walk sets the pace, and a frame has up to four results.
// A job queue of two entries decouples the front from the arithmetic back
// end, which has a reciprocal multiply stage and a correction stage with a
// registered output.
// Reset clears stored engine speed, key byte, key flag and engine flag and
// empties all stages. A stalled m_axis holds its transaction; the queue
// fills and then the front end stops taking frames.
// cfg writes are always accepted; write only while the block is idle.
`default_nettype none
module vehicle_can_signal_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // can_id[10:0], frame_length[14:11], data_byte0..7[78:15], zero pad
  input  wire logic [79:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // signal_value[39:0], key_position[42:40], ignition_state[44:43],
  // engine_running[45], engine_cranking[46], zero pad
  output logic [47:0]      m_axis_tdata,
  // signal_code[4:0]
  output logic [4:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [13:0] cfg_data
);
  logic [13:0] thr;
  vcsd_pkg::job_t fj, qj, rj;
  logic fv, fr, qv, qr;

  assign cfg_ready = 1'b1;
  // threshold register
  always_ff @(posedge clk) begin
    if (rst) thr <= vcsd_pkg::ThrReset;
    else if (cfg_valid && cfg_ready) thr <= cfg_data;
  end

  vcsd_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .can_id(s_axis_tdata[10:0]), .frame_length(s_axis_tdata[14:11]),
    .data(s_axis_tdata[78:15]), .thr,
    .job(fj), .job_valid(fv), .job_ready(fr)
  );
  vcsd_queue u_queue (
    .clk, .rst, .wr_job(fj), .wr_valid(fv), .wr_ready(fr),
    .rd_job(qj), .rd_valid(qv), .rd_ready(qr)
  );
  vcsd_back u_back (
    .clk, .rst, .job(qj), .job_valid(qv), .job_ready(qr),
    .res(rj), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, rj.engine_cranking, rj.engine_running,
                         rj.ignition_state, rj.key_position, rj.value};
  assign m_axis_tuser = rj.code;
  assign m_axis_tlast = rj.last;
endmodule
`default_nettype wire

### hw/rtl/vcsd_checker.sv
// port-level checker for the can signal decoder, bound to the top level
// uses vehicle_can_signal_decoder_macros.svh
`default_nettype none
`include "vehicle_can_signal_decoder_macros.svh"
module vcsd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [4:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  // stalled result holds
  `VCSD_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}))
  // ignition code never three
  `VCSD_ASSERT_IMPL(a_ign, clk, rst, m_axis_tvalid, m_axis_tdata[44:43] != 2'd3)
  // running and cranking never together
  `VCSD_ASSERT_IMPL(a_run, clk, rst, m_axis_tvalid, !(m_axis_tdata[45] && m_axis_tdata[46]))
endmodule
bind vehicle_can_signal_decoder vcsd_checker u_chk (.*);
`default_nettype wire
